// ===== design/arhb_pkg.sv =====
// Shared types, codes and helper functions for the async response header builder.
// No dependencies; used by every module in design/.
package arhb_pkg;

  // Build-time constants
  localparam int unsigned ScratchSlots       = 64;     // 1..64
  localparam int unsigned SlotStride         = 16;     // bytes between scratch slots
  localparam int unsigned SplitTimeoutCycles = 16000;  // 1..56000
  localparam int unsigned CyclesPerSec       = 8000;

  localparam int unsigned SplitQuot = SplitTimeoutCycles / CyclesPerSec;
  localparam int unsigned SplitRem  = SplitTimeoutCycles % CyclesPerSec;

  localparam int unsigned SlotW  = 6;
  localparam int unsigned CountW = 7;

  // Transaction codes
  localparam logic [3:0] TcWriteQuad    = 4'h0;
  localparam logic [3:0] TcWriteBlock   = 4'h1;
  localparam logic [3:0] TcWriteRsp     = 4'h2;
  localparam logic [3:0] TcReadQuad     = 4'h4;
  localparam logic [3:0] TcReadBlock    = 4'h5;
  localparam logic [3:0] TcReadQuadRsp  = 4'h6;
  localparam logic [3:0] TcReadBlockRsp = 4'h7;
  localparam logic [3:0] TcLock         = 4'h9;
  localparam logic [3:0] TcLockRsp      = 4'hB;

  localparam logic [3:0]  RcodeComplete = 4'h0;
  localparam logic [15:0] BroadcastId   = 16'hFFFF;

  // Fixed quadlet 0 bits: speed S400, retry X
  localparam logic [7:0] SpeedS400 = 8'h02;
  localparam logic [1:0] RetryX    = 2'h1;

  localparam logic [4:0] HdrBytesShort = 5'd12;
  localparam logic [4:0] HdrBytesLong  = 5'd16;
  localparam logic [15:0] LockPayloadLen = 16'd4;

  // Config register indexes (byte address / 4)
  localparam logic [1:0] RegScratchBase  = 2'd0;
  localparam logic [1:0] RegScratchSlots = 2'd1;
  localparam logic [1:0] RegBusyCode     = 2'd2;

  localparam logic [3:0] BusyCodeReset = 4'h4;

  typedef struct packed {
    logic [31:0]       scratch_base;
    logic [CountW-1:0] scratch_slots;
    logic [3:0]        busy_code;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ext_tcode;
    logic [63:0] block_address;
    logic [15:0] block_length;
    logic [31:0] data_value;
    logic [3:0]  resp_code;
    logic [15:0] arrival_stamp;
    logic [15:0] dest_node;
    logic [15:0] source_node;
    logic [5:0]  t_label;
    logic [3:0]  req_tcode;
  } req_t;

  // Packed so that hdr_q0 lands in the low bits of tdata
  typedef struct packed {
    logic [31:0]      scratch_data;
    logic [SlotW-1:0] scratch_slot;
    logic             scratch_write;
    logic [15:0]      deadline;
    logic [15:0]      payload_len;
    logic [63:0]      payload_addr;
    logic [4:0]       header_bytes;
    logic [31:0]      hdr_q3;
    logic [31:0]      hdr_q1;
    logic [31:0]      hdr_q0;
  } rsp_t;

  function automatic logic [31:0] swap32(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Stamp plus split timeout; cycle count carries into 3-bit seconds at 8000.
  function automatic logic [15:0] calc_deadline(logic [15:0] stamp);
    logic [13:0] rem_sum;
    logic [12:0] rem;
    logic [2:0]  q;
    rem_sum = 14'(SplitRem) + {1'b0, stamp[12:0]};
    if (rem_sum >= 14'(2 * CyclesPerSec)) begin
      q   = 3'(SplitQuot + 2);
      rem = 13'(rem_sum - 14'(2 * CyclesPerSec));
    end else if (rem_sum >= 14'(CyclesPerSec)) begin
      q   = 3'(SplitQuot + 1);
      rem = 13'(rem_sum - 14'(CyclesPerSec));
    end else begin
      q   = 3'(SplitQuot);
      rem = rem_sum[12:0];
    end
    return {stamp[15:13] + q, rem};
  endfunction

endpackage

// ===== design/async_response_header_builder.sv =====
// Top level of the async response header builder: stream ports, pipeline registers,
// scratch slot counter. Depends on arhb_pkg, arhb_cfg and arhb_resp.
//
// Takes one received asynchronous request per item and returns the matching
// response header (quadlets 0, 1, 3 and byte count), the payload pointer and
// length, a split-timeout deadline and, for completed locks, a big-endian
// scratch write of the old value. Broadcast requests and unsupported tCodes
// are dropped without a result. Throughput is one item per clock unless
// stalled. The scratch slot counter advances as a completed lock leaves the
// input register, so slots are handed out in arrival order. tready on the
// slave side follows downstream backpressure through the input and result
// registers around the response logic. Config writes go through the APB port;
// the user must ensure no item is in flight; the block does not enforce it.
module async_response_header_builder (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata, low bit up: t_label[5:0], source_node[21:6], dest_node[37:22],
  // arrival_stamp[53:38], resp_code[57:54], data_value[89:58],
  // block_length[105:90], block_address[169:106], ext_tcode[185:170], zero[191:186]
  input  logic [191:0]  s_axis_tdata,
  input  logic [3:0]    s_axis_tuser,   // req_tcode[3:0]
  // response stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata, low bit up: hdr_q0[31:0], hdr_q1[63:32], hdr_q3[95:64],
  // header_bytes[100:96], payload_addr[164:101], payload_len[180:165],
  // deadline[196:181], scratch_write[197], scratch_slot[203:198],
  // scratch_data[235:204], zero[239:236]
  output logic [239:0]  m_axis_tdata,
  // config port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  arhb_pkg::cfg_t cfg;
  arhb_pkg::req_t in_q, in_d;
  arhb_pkg::rsp_t out_q, rsp;
  logic           in_valid_q, in_valid_d;
  logic           out_valid_q, out_valid_d;
  logic [arhb_pkg::SlotW-1:0] next_slot_q, next_slot_d, slot_after;
  logic           has_rsp, take_slot;
  logic           s_acc, out_free, adv;

  arhb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  arhb_resp u_resp (
    .req_i       (in_q),
    .cfg_i       (cfg),
    .next_slot_i (next_slot_q),
    .has_rsp_o   (has_rsp),
    .take_slot_o (take_slot),
    .next_slot_o (slot_after),
    .rsp_o       (rsp)
  );

  // Handshake: result register frees up when empty or being taken;
  // the input register moves on whenever the result register is free.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_d.req_tcode     = s_axis_tuser;
    in_d.t_label       = s_axis_tdata[5:0];
    in_d.source_node   = s_axis_tdata[21:6];
    in_d.dest_node     = s_axis_tdata[37:22];
    in_d.arrival_stamp = s_axis_tdata[53:38];
    in_d.resp_code     = s_axis_tdata[57:54];
    in_d.data_value    = s_axis_tdata[89:58];
    in_d.block_length  = s_axis_tdata[105:90];
    in_d.block_address = s_axis_tdata[169:106];
    in_d.ext_tcode     = s_axis_tdata[185:170];
  end

  assign in_valid_d  = s_acc ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign out_valid_d = adv ? has_rsp : (m_axis_tready ? 1'b0 : out_valid_q);
  assign next_slot_d = (adv && take_slot) ? slot_after : next_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      next_slot_q <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      next_slot_q <= next_slot_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q <= in_d;
    end
    if (adv && has_rsp) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q};

`ifndef SYNTHESIS
  // slot counter only moves when a completed lock leaves the input register
  a_slot_moves_on_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_slot_q != $past(next_slot_q)) |-> $past(adv && take_slot))
    else $error("scratch slot counter moved without a lock");

  // a waiting request is held until it moves on
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_q)))
    else $error("input register lost a stalled request");

  // a scratch write always names a slot inside the configured range and carries the lock payload length
  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.scratch_write) |->
      ({1'b0, out_q.scratch_slot} < cfg.scratch_slots &&
       out_q.payload_len == arhb_pkg::LockPayloadLen))
    else $error("scratch write outside configured slots");
`endif

endmodule

// ===== design/arhb_cfg.sv =====
// APB-style register file for the async response header builder.
// Depends on arhb_pkg.
module arhb_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output arhb_pkg::cfg_t     cfg_o
);

  arhb_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        arhb_pkg::RegScratchBase:  cfg_d.scratch_base  = pwdata;
        arhb_pkg::RegScratchSlots: cfg_d.scratch_slots = pwdata[arhb_pkg::CountW-1:0];
        arhb_pkg::RegBusyCode:     cfg_d.busy_code     = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scratch_base  <= '0;
      cfg_q.scratch_slots <= '0;
      cfg_q.busy_code     <= arhb_pkg::BusyCodeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      arhb_pkg::RegScratchBase:  prdata = cfg_q.scratch_base;
      arhb_pkg::RegScratchSlots: prdata = {{(32 - arhb_pkg::CountW){1'b0}}, cfg_q.scratch_slots};
      arhb_pkg::RegBusyCode:     prdata = {28'd0, cfg_q.busy_code};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/arhb_resp.sv =====
// Combinational response builder: header quadlets, payload, deadline, scratch slot pick.
// Depends on arhb_pkg.
module arhb_resp (
  input  arhb_pkg::req_t                 req_i,
  input  arhb_pkg::cfg_t                 cfg_i,
  input  logic [arhb_pkg::SlotW-1:0]     next_slot_i,
  output logic                           has_rsp_o,
  output logic                           take_slot_o,
  output logic [arhb_pkg::SlotW-1:0]     next_slot_o,
  output arhb_pkg::rsp_t                 rsp_o
);

  logic [arhb_pkg::CountW-1:0] count;
  logic [arhb_pkg::CountW-1:0] slot_inc;
  logic [arhb_pkg::SlotW-1:0]  slot;
  logic [3:0]                  rsp_tcode;
  logic [3:0]                  q1_rcode;
  logic                        complete;

  // usable slots, clamped to what the design provides
  assign count = (cfg_i.scratch_slots > arhb_pkg::CountW'(arhb_pkg::ScratchSlots))
               ? arhb_pkg::CountW'(arhb_pkg::ScratchSlots) : cfg_i.scratch_slots;
  assign slot     = ({1'b0, next_slot_i} >= count) ? '0 : next_slot_i;
  assign slot_inc = {1'b0, slot} + arhb_pkg::CountW'(1);
  assign complete = (req_i.resp_code == arhb_pkg::RcodeComplete);

  always_comb begin
    has_rsp_o   = 1'b1;
    take_slot_o = 1'b0;
    next_slot_o = (slot_inc >= count) ? '0 : slot_inc[arhb_pkg::SlotW-1:0];
    rsp_tcode   = arhb_pkg::TcWriteRsp;
    q1_rcode    = req_i.resp_code;
    rsp_o       = '0;
    rsp_o.header_bytes = arhb_pkg::HdrBytesLong;

    case (req_i.req_tcode) inside
      arhb_pkg::TcWriteQuad, arhb_pkg::TcWriteBlock: begin
        rsp_tcode          = arhb_pkg::TcWriteRsp;
        rsp_o.header_bytes = arhb_pkg::HdrBytesShort;
      end
      arhb_pkg::TcReadQuad: begin
        rsp_tcode = arhb_pkg::TcReadQuadRsp;
        if (complete) rsp_o.hdr_q3 = req_i.data_value;
      end
      arhb_pkg::TcReadBlock: begin
        rsp_tcode = arhb_pkg::TcReadBlockRsp;
        if (complete && (req_i.block_length != '0)) begin
          rsp_o.hdr_q3       = {req_i.block_length, 16'd0};
          rsp_o.payload_len  = req_i.block_length;
          rsp_o.payload_addr = req_i.block_address;
        end
      end
      arhb_pkg::TcLock: begin
        rsp_tcode = arhb_pkg::TcLockRsp;
        if (complete) begin
          if (count == '0) begin
            q1_rcode = cfg_i.busy_code;
          end else begin
            take_slot_o         = 1'b1;
            rsp_o.scratch_write = 1'b1;
            rsp_o.scratch_slot  = slot;
            rsp_o.scratch_data  = arhb_pkg::swap32(req_i.data_value);
            rsp_o.payload_len   = arhb_pkg::LockPayloadLen;
            rsp_o.payload_addr  = 64'(cfg_i.scratch_base)
                                + 64'(slot) * 64'(arhb_pkg::SlotStride);
            rsp_o.hdr_q3        = {arhb_pkg::LockPayloadLen, req_i.ext_tcode};
          end
        end
      end
      default: has_rsp_o = 1'b0;
    endcase

    // broadcast requests are never answered
    if (req_i.dest_node == arhb_pkg::BroadcastId) has_rsp_o = 1'b0;
    if (!has_rsp_o) take_slot_o = 1'b0;

    rsp_o.hdr_q0   = {8'd0, arhb_pkg::SpeedS400, req_i.t_label, arhb_pkg::RetryX,
                      rsp_tcode, 4'd0};
    rsp_o.hdr_q1   = {req_i.source_node, q1_rcode, 12'd0};
    rsp_o.deadline = arhb_pkg::calc_deadline(req_i.arrival_stamp);
  end

endmodule
